@@ hdl/dlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_pkg
// Shared types, codes and helpers of the dense layer training engine.
// ----------------------------------------------------------------------------
package dlt_pkg;

  localparam int LR_FRAC = 16;

  localparam logic [6:0]  IN_SIZE_RST    = 7'd64;
  localparam logic [6:0]  NRN_CNT_RST    = 7'd64;
  localparam logic [15:0] LEARN_RATE_RST = 16'd655;

  localparam logic [1:0] REG_IN_SIZE    = 2'd0;
  localparam logic [1:0] REG_NRN_CNT    = 2'd1;
  localparam logic [1:0] REG_LEARN_RATE = 2'd2;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [2:0] {
    REQ_WR_W  = 3'd0,
    REQ_WR_B  = 3'd1,
    REQ_WR_X  = 3'd2,
    REQ_WR_G  = 3'd3,
    REQ_FWD   = 3'd4,
    REQ_BWD   = 3'd5,
    REQ_SGD   = 3'd6,
    REQ_RD_W  = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    KIND_FWD  = 2'd0,
    KIND_GRAD = 2'd1,
    KIND_RB   = 2'd2,
    KIND_DONE = 2'd3
  } out_kind_e;

  typedef enum logic [2:0] {
    MUL_WX,   // weight * input
    MUL_DG,   // derivative * gradient
    MUL_XB,   // input * bias delta
    MUL_WB,   // weight * bias delta
    MUL_LW,   // rate * weight delta
    MUL_LB    // rate * bias delta
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_CLR,
    ACC_ADD_P,
    ACC_ADD_B
  } acc_op_e;

  typedef struct packed {
    logic      take;
    logic      mul_en;
    mul_sel_e  mul_sel;
    logic      sh_lr;
    acc_op_e   acc_op;
    logic      w_upd;
    logic      wd_wr;
    logic      wd_zero;
    logic      b_upd;
    logic      bd_wr;
    logic      bd_zero;
    logic      emit;
    out_kind_e kind;
    logic      last;
    logic      use_req;
    logic [5:0] i_idx;
    logic [5:0] j_idx;
  } dlt_cmd_t;

  typedef struct packed {
    logic out_free;
  } dlt_sts_t;

  function automatic logic signed [63:0] sx64(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > SAT_MAX) begin
      return 32'h7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

@@ hdl/dlt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/dlt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_datapath
// Stores, shared multiplier, accumulator and output register of the engine.
// ----------------------------------------------------------------------------
module dlt_datapath #(
  parameter int MAX_IN    = 64,
  parameter int MAX_OUT   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [79:0]       s_tdata_i,
  input  logic [2:0]        s_tuser_i,
  input  logic [15:0]       lr_i,
  input  dlt_pkg::dlt_cmd_t cmd_i,
  output dlt_pkg::dlt_sts_t sts_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [39:0]       m_tdata_o,
  output logic [1:0]        m_tuser_o,
  output logic              m_tlast_o
);

  localparam int LIM_IN = (MAX_IN < 64) ? MAX_IN : 64;
  localparam int CW     = (LIM_IN > 1) ? $clog2(LIM_IN) : 1;
  localparam int OW     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int AW     = OW + CW;

  logic [5:0]  in_row, in_col;
  logic [31:0] in_v1, in_v2;
  logic        in_row_ok, in_col_ok;
  dlt_pkg::req_e in_req;

  logic [5:0]  row_q, col_q;
  logic        rb_ok_q;

  logic [AW-1:0] loop_addr, req_addr, in_addr;

  logic [31:0] w_rd, b_rd, x_rd, wd_rd, bd_rd;
  logic [63:0] gd_rd;

  logic        w_we, b_we, x_we, gd_we, wd_we, bd_we;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [OW-1:0] b_waddr;
  logic [31:0] w_wdata, b_wdata, wd_wdata, bd_wdata;

  logic signed [32:0] ma, mb;
  logic signed [63:0] prod_q;
  logic signed [63:0] fsh;
  logic signed [63:0] acc_q, acc_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q;
  logic [5:0]  out_idx_q, out_idx_d;
  logic [31:0] out_val_q, out_val_d;
  logic        out_last_q;

  assign in_row    = s_tdata_i[5:0];
  assign in_col    = s_tdata_i[11:6];
  assign in_v1     = s_tdata_i[43:12];
  assign in_v2     = s_tdata_i[75:44];
  assign in_req    = dlt_pkg::req_e'(s_tuser_i);
  assign in_row_ok = 7'(in_row) < 7'(MAX_OUT);
  assign in_col_ok = 7'(in_col) < 7'(LIM_IN);

  assign loop_addr = {OW'(cmd_i.j_idx), CW'(cmd_i.i_idx)};
  assign req_addr  = {OW'(row_q), CW'(col_q)};
  assign in_addr   = {OW'(in_row), CW'(in_col)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      row_q   <= in_row;
      col_q   <= in_col;
      rb_ok_q <= in_row_ok && in_col_ok;
    end
  end

  // floor of the product: arithmetic shift drops the low bits
  assign fsh = cmd_i.sh_lr ? (prod_q >>> dlt_pkg::LR_FRAC) : (prod_q >>> FRAC_BITS);

  assign w_we    = (cmd_i.take && in_req == dlt_pkg::REQ_WR_W && in_row_ok && in_col_ok)
                   || cmd_i.w_upd;
  assign w_waddr = cmd_i.take ? in_addr : loop_addr;
  assign w_wdata = cmd_i.take ? in_v1 : dlt_pkg::sat32(dlt_pkg::sx64(w_rd) - fsh);
  assign w_raddr = cmd_i.use_req ? req_addr : loop_addr;

  assign b_we    = (cmd_i.take && in_req == dlt_pkg::REQ_WR_B && in_row_ok) || cmd_i.b_upd;
  assign b_waddr = cmd_i.take ? OW'(in_row) : OW'(cmd_i.j_idx);
  assign b_wdata = cmd_i.take ? in_v1 : dlt_pkg::sat32(dlt_pkg::sx64(b_rd) - fsh);

  assign x_we  = cmd_i.take && in_req == dlt_pkg::REQ_WR_X && in_col_ok;
  assign gd_we = cmd_i.take && in_req == dlt_pkg::REQ_WR_G && in_row_ok;

  assign wd_we    = cmd_i.wd_wr || cmd_i.wd_zero;
  assign wd_wdata = cmd_i.wd_zero ? 32'd0 : dlt_pkg::sat32(fsh);
  assign bd_we    = cmd_i.bd_wr || cmd_i.bd_zero;
  assign bd_wdata = cmd_i.bd_zero ? 32'd0 : dlt_pkg::sat32(fsh);

  dlt_ram #(.WIDTH(32), .DEPTH(2**AW)) u_w_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rd)
  );

  dlt_ram #(.WIDTH(32), .DEPTH(2**AW)) u_wd_ram (
    .clk_i, .we_i(wd_we), .waddr_i(loop_addr), .wdata_i(wd_wdata),
    .raddr_i(loop_addr), .rdata_o(wd_rd)
  );

  dlt_ram #(.WIDTH(32), .DEPTH(2**OW)) u_b_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(OW'(cmd_i.j_idx)), .rdata_o(b_rd)
  );

  dlt_ram #(.WIDTH(32), .DEPTH(2**OW)) u_bd_ram (
    .clk_i, .we_i(bd_we), .waddr_i(OW'(cmd_i.j_idx)), .wdata_i(bd_wdata),
    .raddr_i(OW'(cmd_i.j_idx)), .rdata_o(bd_rd)
  );

  dlt_ram #(.WIDTH(32), .DEPTH(2**CW)) u_x_ram (
    .clk_i, .we_i(x_we), .waddr_i(CW'(in_col)), .wdata_i(in_v1),
    .raddr_i(CW'(cmd_i.i_idx)), .rdata_o(x_rd)
  );

  // gradient in the low word, activation derivative in the high word
  dlt_ram #(.WIDTH(64), .DEPTH(2**OW)) u_gd_ram (
    .clk_i, .we_i(gd_we), .waddr_i(OW'(in_row)), .wdata_i({in_v2, in_v1}),
    .raddr_i(OW'(cmd_i.j_idx)), .rdata_o(gd_rd)
  );

  always_comb begin
    case (cmd_i.mul_sel)
      dlt_pkg::MUL_WX: begin
        ma = {w_rd[31], w_rd};
        mb = {x_rd[31], x_rd};
      end
      dlt_pkg::MUL_DG: begin
        ma = {gd_rd[63], gd_rd[63:32]};
        mb = {gd_rd[31], gd_rd[31:0]};
      end
      dlt_pkg::MUL_XB: begin
        ma = {x_rd[31], x_rd};
        mb = {bd_rd[31], bd_rd};
      end
      dlt_pkg::MUL_WB: begin
        ma = {w_rd[31], w_rd};
        mb = {bd_rd[31], bd_rd};
      end
      dlt_pkg::MUL_LW: begin
        ma = {17'd0, lr_i};
        mb = {wd_rd[31], wd_rd};
      end
      dlt_pkg::MUL_LB: begin
        ma = {17'd0, lr_i};
        mb = {bd_rd[31], bd_rd};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= 64'(ma * mb);
    end
  end

  always_comb begin
    case (cmd_i.acc_op)
      dlt_pkg::ACC_CLR:   acc_d = '0;
      dlt_pkg::ACC_ADD_P: acc_d = acc_q + fsh;
      dlt_pkg::ACC_ADD_B: acc_d = acc_q + dlt_pkg::sx64(b_rd);
      default:            acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    case (cmd_i.kind)
      dlt_pkg::KIND_FWD: begin
        out_idx_d = cmd_i.j_idx;
        out_val_d = dlt_pkg::sat32(acc_q);
      end
      dlt_pkg::KIND_GRAD: begin
        out_idx_d = cmd_i.i_idx;
        out_val_d = dlt_pkg::sat32(acc_q);
      end
      dlt_pkg::KIND_RB: begin
        out_idx_d = col_q;
        out_val_d = rb_ok_q ? w_rd : 32'd0;
      end
      default: begin
        out_idx_d = '0;
        out_val_d = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_idx_q  <= out_idx_d;
      out_val_q  <= out_val_d;
      out_last_q <= cmd_i.last;
    end
  end

  assign sts_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, out_val_q, out_idx_q};
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

endmodule

@@ hdl/dlt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_ctrl
// Sequencer for clearing, forward, backward, update and readback runs.
// ----------------------------------------------------------------------------
module dlt_ctrl #(
  parameter int MAX_IN  = 64,
  parameter int MAX_OUT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic [2:0]        s_req_i,
  output logic              s_ready_o,
  input  logic [5:0]        ni_m1_i,
  input  logic [5:0]        no_m1_i,
  input  dlt_pkg::dlt_sts_t sts_i,
  output dlt_pkg::dlt_cmd_t cmd_o
);

  localparam int LIM_IN = (MAX_IN < 64) ? MAX_IN : 64;
  localparam logic [5:0] CLR_I_LAST = 6'(LIM_IN - 1);
  localparam logic [5:0] CLR_J_LAST = 6'(MAX_OUT - 1);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_F_RD, ST_F_MUL, ST_F_ACC, ST_F_BIAS, ST_F_EMIT,
    ST_B1_RD, ST_B1_MUL, ST_B1_WR,
    ST_B2_RD, ST_B2_M1, ST_B2_M2, ST_B2_ACC, ST_B2_EMIT,
    ST_S_RD, ST_S_MUL, ST_S_UPD, ST_S_BMUL, ST_S_BUPD, ST_S_DONE,
    ST_R_RD, ST_R_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] i_q, i_d, j_q, j_d;
  logic       i_last, j_last;

  assign i_last = (i_q == ni_m1_i);
  assign j_last = (j_q == no_m1_i);

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    s_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.i_idx = i_q;
    cmd_o.j_idx = j_q;
    case (state_q)
      ST_CLEAR: begin
        // zero both delta stores once after reset
        cmd_o.wd_zero = 1'b1;
        cmd_o.bd_zero = 1'b1;
        if (i_q == CLR_I_LAST) begin
          i_d = '0;
          if (j_q == CLR_J_LAST) begin
            j_d     = '0;
            state_d = ST_IDLE;
          end else begin
            j_d = j_q + 6'd1;
          end
        end else begin
          i_d = i_q + 6'd1;
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.take   = 1'b1;
          cmd_o.acc_op = dlt_pkg::ACC_CLR;
          i_d = '0;
          j_d = '0;
          case (dlt_pkg::req_e'(s_req_i))
            dlt_pkg::REQ_FWD:  state_d = ST_F_RD;
            dlt_pkg::REQ_BWD:  state_d = ST_B1_RD;
            dlt_pkg::REQ_SGD:  state_d = ST_S_RD;
            dlt_pkg::REQ_RD_W: state_d = ST_R_RD;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_F_RD: state_d = ST_F_MUL;
      ST_F_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dlt_pkg::MUL_WX;
        state_d = ST_F_ACC;
      end
      ST_F_ACC: begin
        cmd_o.acc_op = dlt_pkg::ACC_ADD_P;
        if (i_last) begin
          state_d = ST_F_BIAS;
        end else begin
          i_d     = i_q + 6'd1;
          state_d = ST_F_RD;
        end
      end
      ST_F_BIAS: begin
        cmd_o.acc_op = dlt_pkg::ACC_ADD_B;
        state_d = ST_F_EMIT;
      end
      ST_F_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = dlt_pkg::KIND_FWD;
          cmd_o.last   = j_last;
          cmd_o.acc_op = dlt_pkg::ACC_CLR;
          if (j_last) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + 6'd1;
            i_d     = '0;
            state_d = ST_F_RD;
          end
        end
      end
      ST_B1_RD: state_d = ST_B1_MUL;
      ST_B1_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dlt_pkg::MUL_DG;
        state_d = ST_B1_WR;
      end
      ST_B1_WR: begin
        cmd_o.bd_wr = 1'b1;
        if (j_last) begin
          j_d     = '0;
          i_d     = '0;
          state_d = ST_B2_RD;
        end else begin
          j_d     = j_q + 6'd1;
          state_d = ST_B1_RD;
        end
      end
      ST_B2_RD: state_d = ST_B2_M1;
      ST_B2_M1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dlt_pkg::MUL_XB;
        state_d = ST_B2_M2;
      end
      ST_B2_M2: begin
        // weight delta from x*bd, multiplier moves on to w*bd
        cmd_o.wd_wr   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dlt_pkg::MUL_WB;
        state_d = ST_B2_ACC;
      end
      ST_B2_ACC: begin
        cmd_o.acc_op = dlt_pkg::ACC_ADD_P;
        if (j_last) begin
          state_d = ST_B2_EMIT;
        end else begin
          j_d     = j_q + 6'd1;
          state_d = ST_B2_RD;
        end
      end
      ST_B2_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = dlt_pkg::KIND_GRAD;
          cmd_o.last   = i_last;
          cmd_o.acc_op = dlt_pkg::ACC_CLR;
          if (i_last) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 6'd1;
            j_d     = '0;
            state_d = ST_B2_RD;
          end
        end
      end
      ST_S_RD: state_d = ST_S_MUL;
      ST_S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dlt_pkg::MUL_LW;
        state_d = ST_S_UPD;
      end
      ST_S_UPD: begin
        cmd_o.sh_lr   = 1'b1;
        cmd_o.w_upd   = 1'b1;
        cmd_o.wd_zero = 1'b1;
        if (i_last) begin
          state_d = ST_S_BMUL;
        end else begin
          i_d     = i_q + 6'd1;
          state_d = ST_S_RD;
        end
      end
      ST_S_BMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dlt_pkg::MUL_LB;
        state_d = ST_S_BUPD;
      end
      ST_S_BUPD: begin
        cmd_o.sh_lr   = 1'b1;
        cmd_o.b_upd   = 1'b1;
        cmd_o.bd_zero = 1'b1;
        if (j_last) begin
          state_d = ST_S_DONE;
        end else begin
          j_d     = j_q + 6'd1;
          i_d     = '0;
          state_d = ST_S_RD;
        end
      end
      ST_S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = dlt_pkg::KIND_DONE;
          cmd_o.last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_R_RD: begin
        cmd_o.use_req = 1'b1;
        state_d = ST_R_EMIT;
      end
      ST_R_EMIT: begin
        cmd_o.use_req = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = dlt_pkg::KIND_RB;
          cmd_o.last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

endmodule

@@ hdl/dense_layer_train_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_train_engine
// Fully connected layer with SGD training in signed fixed point.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis stream, results leave on m_axis, and the APB
// port holds the input count, neuron count and learn_rate (write only while
// idle). Store writes (weight, bias, input, gradient pair) are done as they
// are taken, so the sequencer stays idle and ready for the next request. In
// forward, backward and SGD runs the sequencer walks the weight RAM one
// element per step through a single shared multiplier and a 64-bit accumulator.
// One request is worked at a time; the next is taken as soon as the
// sequencer is idle, even while the last result still sits in the output
// register. When the receiver stalls, the sequencer holds before each
// result until the output register frees up.
// After reset a clearing pass zeroes the delta stores with s_axis_tready low;
// APB stays open.
// ----------------------------------------------------------------------------
module dense_layer_train_engine #(
  parameter int MAX_IN    = 64,
  parameter int MAX_OUT   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // row[5:0], col[11:6], in_value[43:12],
                                      // in_value2[75:44], zero pad
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_index[5:0], out_value[37:6], zero pad
  output logic [1:0]  m_axis_tuser,   // out_kind[1:0]
  output logic        m_axis_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LIM_IN = (MAX_IN < 64) ? MAX_IN : 64;

  logic [6:0]  in_size_q, nrn_cnt_q;
  logic [15:0] lr_q;
  logic        cfg_wr;
  logic [6:0]  ni_eff, no_eff;
  logic [5:0]  ni_m1, no_m1;

  dlt_pkg::dlt_cmd_t cmd;
  dlt_pkg::dlt_sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q <= dlt_pkg::IN_SIZE_RST;
      nrn_cnt_q <= dlt_pkg::NRN_CNT_RST;
      lr_q      <= dlt_pkg::LEARN_RATE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dlt_pkg::REG_IN_SIZE:    in_size_q <= pwdata[6:0];
        dlt_pkg::REG_NRN_CNT:    nrn_cnt_q <= pwdata[6:0];
        dlt_pkg::REG_LEARN_RATE: lr_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dlt_pkg::REG_IN_SIZE:    prdata = {25'd0, in_size_q};
      dlt_pkg::REG_NRN_CNT:    prdata = {25'd0, nrn_cnt_q};
      dlt_pkg::REG_LEARN_RATE: prdata = {16'd0, lr_q};
      default:                 prdata = '0;
    endcase
  end

  // sizes in use: zero acts as one, large values clip to the store size
  always_comb begin
    if (in_size_q == 7'd0) begin
      ni_eff = 7'd1;
    end else if (in_size_q > 7'(LIM_IN)) begin
      ni_eff = 7'(LIM_IN);
    end else begin
      ni_eff = in_size_q;
    end
    if (nrn_cnt_q == 7'd0) begin
      no_eff = 7'd1;
    end else if (nrn_cnt_q > 7'(MAX_OUT)) begin
      no_eff = 7'(MAX_OUT);
    end else begin
      no_eff = nrn_cnt_q;
    end
  end

  assign ni_m1 = 6'(ni_eff - 7'd1);
  assign no_m1 = 6'(no_eff - 7'd1);

  dlt_ctrl #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT)) u_ctrl (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid),
    .s_req_i   (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .ni_m1_i   (ni_m1),
    .no_m1_i   (no_m1),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dlt_datapath #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni,
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .lr_i       (lr_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

@@ test/dense_layer_train_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_train_engine_tb
// Self-checking bench for the dense layer training engine: the corner of the
// weight, bias, input and gradient stores used by every run is preloaded,
// then a directed table and random requests run through several size and
// rate settings. A bit-exact predictor of the layer arithmetic checks every
// forward sum, input gradient, readback and update acknowledge, while both
// streams idle at random in all but the last two settings.
// ----------------------------------------------------------------------------
module dense_layer_train_engine_tb;

  localparam int LIMIT = 2000000;
  localparam int NW    = 64;
  localparam int FILL  = 4;

  typedef struct {
    dlt_pkg::req_e req;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] v1;
    logic [31:0] v2;
    logic        chk;      // typed-in value overrides the prediction
    logic [31:0] val;
  } layer_req_t;

  typedef struct {
    dlt_pkg::out_kind_e kind;
    logic [5:0]  idx;
    logic [31:0] val;
    logic        last;
  } layer_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // row, col, in_value, in_value2, pad
  logic [2:0]  s_axis_tuser = '0;  // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // out_index, out_value, pad
  logic [1:0]  m_axis_tuser;       // out_kind
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dense_layer_train_engine uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] wt_mem [NW*NW];
  logic [31:0] wd_mem [NW*NW];
  logic [31:0] b_mem  [NW];
  logic [31:0] bd_mem [NW];
  logic [31:0] x_mem  [NW];
  logic [31:0] g_mem  [NW];
  logic [31:0] d_mem  [NW];
  logic [6:0]  in_sz  = dlt_pkg::IN_SIZE_RST;
  logic [6:0]  out_sz = dlt_pkg::NRN_CNT_RST;
  logic [15:0] lrate  = dlt_pkg::LEARN_RATE_RST;

  layer_res_t  pending_q [$];
  int          mism = 0;
  int          cycles = 0;
  int          snd_idle = 36;
  int          rcv_idle = 48;

  function automatic logic signed [63:0] sext(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // fixed point product, low bits dropped (floor)
  function automatic logic signed [63:0] fxmul(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = sext(a) * sext(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] rate_mul(input logic [31:0] d);
    logic signed [63:0] p;
    p = $signed({48'd0, lrate}) * sext(d);
    return p >>> dlt_pkg::LR_FRAC;
  endfunction

  function automatic int n_in();
    return (in_sz == 0) ? 1 : (in_sz > NW) ? NW : int'(in_sz);
  endfunction

  function automatic int n_out();
    return (out_sz == 0) ? 1 : (out_sz > NW) ? NW : int'(out_sz);
  endfunction

  function automatic logic [31:0] rnd_val();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(7))
      0, 1:    return v;
      2:       return {{14{v[31]}}, v[17:0]};
      default: return {{12{v[31]}}, v[19:0]};
    endcase
  endfunction

  task automatic emit(input dlt_pkg::out_kind_e k, input int idx, input logic [31:0] v,
                      input logic l);
    layer_res_t r;
    r.kind = k;
    r.idx  = idx[5:0];
    r.val  = v;
    r.last = l;
    pending_q.push_back(r);
  endtask

  task automatic model_layer(input layer_req_t q);
    int ni, no, k;
    logic signed [63:0] acc;
    logic signed [63:0] gacc [NW];
    logic [31:0] bdv;
    ni = n_in();
    no = n_out();
    case (q.req)
      dlt_pkg::REQ_WR_W: wt_mem[q.row*NW + q.col] = q.v1;
      dlt_pkg::REQ_WR_B: b_mem[q.row] = q.v1;
      dlt_pkg::REQ_WR_X: x_mem[q.col] = q.v1;
      dlt_pkg::REQ_WR_G: begin
        g_mem[q.row] = q.v1;
        d_mem[q.row] = q.v2;
      end
      dlt_pkg::REQ_FWD: begin
        for (int j = 0; j < no; j++) begin
          acc = 0;
          for (int i = 0; i < ni; i++) acc += fxmul(wt_mem[j*NW + i], x_mem[i]);
          acc += sext(b_mem[j]);
          emit(dlt_pkg::KIND_FWD, j, clip32(acc), j + 1 == no);
        end
      end
      dlt_pkg::REQ_BWD: begin
        for (int i = 0; i < ni; i++) gacc[i] = 0;
        for (int j = 0; j < no; j++) begin
          bdv = clip32(fxmul(d_mem[j], g_mem[j]));
          bd_mem[j] = bdv;
          for (int i = 0; i < ni; i++) begin
            wd_mem[j*NW + i] = clip32(fxmul(x_mem[i], bdv));
            gacc[i] += fxmul(wt_mem[j*NW + i], bdv);
          end
        end
        for (int i = 0; i < ni; i++)
          emit(dlt_pkg::KIND_GRAD, i, clip32(gacc[i]), i + 1 == ni);
      end
      dlt_pkg::REQ_SGD: begin
        for (int j = 0; j < no; j++) begin
          for (int i = 0; i < ni; i++) begin
            k = j*NW + i;
            wt_mem[k] = clip32(sext(wt_mem[k]) - rate_mul(wd_mem[k]));
            wd_mem[k] = '0;
          end
          b_mem[j]  = clip32(sext(b_mem[j]) - rate_mul(bd_mem[j]));
          bd_mem[j] = '0;
        end
        emit(dlt_pkg::KIND_DONE, 0, '0, 1'b1);
      end
      default: emit(dlt_pkg::KIND_RB, q.col, wt_mem[q.row*NW + q.col], 1'b1);
    endcase
    if (q.chk) pending_q[$].val = q.val;
  endtask

  // values are stable between edges, so the negedge sees what the next edge takes
  task automatic send_req(input layer_req_t q);
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.req;
    s_axis_tdata  <= {4'd0, q.v2, q.v1, q.col, q.row};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    model_layer(q);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      dlt_pkg::REG_IN_SIZE: in_sz  = v[6:0];
      dlt_pkg::REG_NRN_CNT: out_sz = v[6:0];
      default:              lrate  = v[15:0];
    endcase
  endtask

  task automatic set_layer(input int ni, input int no, input int lr);
    drain();
    apb_write(dlt_pkg::REG_IN_SIZE, ni);
    apb_write(dlt_pkg::REG_NRN_CNT, no);
    apb_write(dlt_pkg::REG_LEARN_RATE, lr);
  endtask

  function automatic layer_req_t mk_req(input dlt_pkg::req_e r, input int row, input int col,
                                        input logic [31:0] v1, input logic [31:0] v2,
                                        input logic chk, input logic [31:0] val);
    layer_req_t q;
    q.req = r;
    q.row = row[5:0];
    q.col = col[5:0];
    q.v1  = v1;
    q.v2  = v2;
    q.chk = chk;
    q.val = val;
    return q;
  endfunction

  // indices stay inside the preloaded corner
  function automatic layer_req_t rnd_req();
    int p;
    dlt_pkg::req_e r;
    p = $urandom_range(99);
    if (p < 45)      r = dlt_pkg::req_e'($urandom_range(3));
    else if (p < 58) r = dlt_pkg::REQ_FWD;
    else if (p < 70) r = dlt_pkg::REQ_BWD;
    else if (p < 80) r = dlt_pkg::REQ_SGD;
    else             r = dlt_pkg::REQ_RD_W;
    return mk_req(r, $urandom_range(FILL - 1), $urandom_range(FILL - 1), rnd_val(), rnd_val(),
                  1'b0, '0);
  endfunction

  // receiver stall and result check
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rcv_idle);

  always @(negedge clk_i) begin
    layer_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result kind=%0d idx=%0d val=%h", m_axis_tuser,
                                 m_axis_tdata[5:0], m_axis_tdata[37:6]);
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tuser != e.kind || m_axis_tdata[5:0] != e.idx ||
            m_axis_tdata[37:6] != e.val || m_axis_tlast != e.last) begin
          mism++;
          if (mism <= 10)
            $display("mismatch exp kind=%0d idx=%0d val=%h last=%b  got %0d %0d %h %b",
                     e.kind, e.idx, e.val, e.last, m_axis_tuser, m_axis_tdata[5:0],
                     m_axis_tdata[37:6], m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    layer_req_t dir_tab [$];
    for (int k = 0; k < NW*NW; k++) begin
      wt_mem[k] = '0;
      wd_mem[k] = '0;
    end
    for (int k = 0; k < NW; k++) begin
      b_mem[k] = '0; bd_mem[k] = '0; x_mem[k] = '0; g_mem[k] = '0; d_mem[k] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sizes of zero act as one
    set_layer(0, 0, 65535);

    // every store entry in use is written before anything reads it
    for (int j = 0; j < FILL; j++)
      for (int i = 0; i < FILL; i++)
        send_req(mk_req(dlt_pkg::REQ_WR_W, j, i, rnd_val(), '0, 1'b0, '0));
    for (int k = 0; k < FILL; k++) begin
      send_req(mk_req(dlt_pkg::REQ_WR_B, k, 0, rnd_val(), '0, 1'b0, '0));
      send_req(mk_req(dlt_pkg::REQ_WR_X, 0, k, rnd_val(), '0, 1'b0, '0));
      send_req(mk_req(dlt_pkg::REQ_WR_G, k, 0, rnd_val(), rnd_val(), 1'b0, '0));
    end

    dir_tab.push_back(mk_req(dlt_pkg::REQ_WR_W, 0, 0, 32'h7FFF_FFFF, '0, 1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_RD_W, 0, 0, '0, '0, 1'b1, 32'h7FFF_FFFF));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_WR_W, 63, 63, 32'h8000_0000, '1, 1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_RD_W, 63, 63, '1, '1, 1'b1, 32'h8000_0000));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_WR_B, 63, 0, 32'h7FFF_FFFF, '0, 1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_WR_B, 0, 0, 32'h8000_0000, '0, 1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_WR_X, 0, 63, 32'h8000_0000, '0, 1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_WR_X, 0, 0, 32'h7FFF_FFFF, '0, 1'b0, '0));
    // extreme gradient pairs: the first product saturates, the second just fits
    dir_tab.push_back(mk_req(dlt_pkg::REQ_WR_G, 0, 0, 32'h8000_0000, 32'h8000_0000,
                             1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_WR_G, 63, 0, 32'h7FFF_FFFF, 32'h0001_0000,
                             1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_FWD, 0, 0, '0, '0, 1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_BWD, 0, 0, '0, '0, 1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_SGD, 0, 0, '0, '0, 1'b1, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_RD_W, 0, 0, '0, '0, 1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_RD_W, 63, 63, '0, '0, 1'b0, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_SGD, 0, 0, '0, '0, 1'b1, '0));
    dir_tab.push_back(mk_req(dlt_pkg::REQ_FWD, 0, 0, '0, '0, 1'b0, '0));
    foreach (dir_tab[n]) send_req(dir_tab[n]);

    // rates at both ends
    set_layer(FILL, FILL, 65535);
    for (int n = 0; n < 22; n++) begin
      send_req(rnd_req());
      if (n == 8) drain();
    end

    snd_idle = 48;
    rcv_idle = 36;
    set_layer(FILL - 1, FILL, 0);
    for (int n = 0; n < 22; n++) send_req(rnd_req());

    snd_idle = 0;
    rcv_idle = 0;
    set_layer($urandom_range(1, FILL), $urandom_range(1, FILL), $urandom_range(65535));
    for (int n = 0; n < 11; n++) send_req(rnd_req());
    set_layer(1, 1, $urandom_range(65535));
    for (int n = 0; n < 11; n++) send_req(rnd_req());

    drain();
    repeat (50) @(posedge clk_i);
    if (mism == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ dense_layer_train_engine.f @@
hdl/dlt_pkg.sv
hdl/dlt_ram.sv
hdl/dlt_datapath.sv
hdl/dlt_ctrl.sv
hdl/dense_layer_train_engine.sv
test/dense_layer_train_engine_tb.sv
